// File: sv/compare_alarm_scheduler_top_assert.svh
// ----------------------------------------------------------------------------
// compare_alarm_scheduler_top_assert.svh
// Assertion macros shared by the compare alarm scheduler modules.
// ----------------------------------------------------------------------------
`ifndef COMPARE_ALARM_SCHEDULER_TOP_ASSERT_SVH
`define COMPARE_ALARM_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CAS_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define CAS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// File: sv/cas_pkg.sv
// ----------------------------------------------------------------------------
// cas_pkg
// Types and constants shared by the compare alarm scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cas_pkg;

   localparam int unsigned DIV_WIDTH    = 17;  // dividend and quotient bits
   localparam int unsigned REM_WIDTH    = 16;  // divisor and remainder bits
   localparam int unsigned NOW_WIDTH    = 48;  // absolute count
   localparam int unsigned TARGET_WIDTH = 49;  // absolute count plus a delta
   localparam int unsigned IN_WIDTH     = 64;
   localparam int unsigned OUT_WIDTH    = 72;
   localparam int unsigned MODE_WIDTH   = 3;

   localparam logic [MODE_WIDTH-1:0] MODE_SCHEDULE = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_TICK     = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_MATCH    = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_READ     = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_INIT     = 3'd4;

   typedef struct packed {
      logic load;
      logic mul_now;
      logic mul_us;
      logic sched_div;
      logic sched_set;
      logic arm_eval;
      logic arm_div;
      logic commit;
   } cas_cmd_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic                  div_busy;
      logic                  arm_ok;
      logic                  out_busy;
   } cas_status_type;

endpackage

// File: sv/cas_div.sv
// ----------------------------------------------------------------------------
// cas_div
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cas_pkg::DIV_WIDTH-1:0] dividend,
   input  logic [cas_pkg::REM_WIDTH-1:0] divisor,
   output logic                          busy,
   output logic [cas_pkg::DIV_WIDTH-1:0] quotient,
   output logic [cas_pkg::REM_WIDTH-1:0] remainder
);
   import cas_pkg::*;

   localparam int unsigned CNT_WIDTH = $clog2(DIV_WIDTH + 1);

   logic [DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [REM_WIDTH-1:0] rem_ff, rem_in;
   logic [REM_WIDTH-1:0] div_ff, div_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;

   logic [REM_WIDTH:0]   partial;
   logic [REM_WIDTH:0]   reduced;
   logic                 take;

   assign partial = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign reduced = partial - {1'b0, div_ff};
   assign take    = partial >= {1'b0, div_ff};

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
         count_in = CNT_WIDTH'(DIV_WIDTH);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in   = take ? reduced[REM_WIDTH-1:0] : partial[REM_WIDTH-1:0];
         quo_in   = {quo_ff[DIV_WIDTH-2:0], take};
         count_in = count_ff - 1'b1;
         busy_in  = count_ff != CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/cas_dp.sv
// ----------------------------------------------------------------------------
// cas_dp
// Datapath: absolute count, microsecond time, target and compare arithmetic,
// alarm state and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "compare_alarm_scheduler_top_assert.svh"

module cas_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  cas_pkg::cas_cmd_type           cmd,
   output cas_pkg::cas_status_type        status,
   input  logic [cas_pkg::IN_WIDTH-1:0]   req_tdata,   // period_ticks, fine_count, alarm_time_us
   input  logic [cas_pkg::MODE_WIDTH-1:0] req_tuser,   // mode
   input  logic [15:0]                    counts_per_period,
   input  logic [9:0]                     count_us,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   // compare_written, compare_value, compare_enable, fire, now_us, alarms_taken
   output logic [cas_pkg::OUT_WIDTH-1:0]  rsp_tdata
);
   import cas_pkg::*;

   // latched item
   logic [MODE_WIDTH-1:0]   mode_ff;
   logic [31:0]             ticks_ff;
   logic [15:0]             fine_ff;
   logic [15:0]             alarm_ff;

   logic [NOW_WIDTH-1:0]    now_ff;
   logic [15:0]             now_us_ff;
   logic [TARGET_WIDTH-1:0] target_ff, target_in;
   logic                    armed_ff, armed_in;
   logic                    irq_ff, irq_in;
   logic [31:0]             match_ff, match_in;
   logic                    arm_ok_ff;
   logic [15:0]             dist_ff;

   // result register
   logic                    rsp_valid_ff;
   logic                    rsp_written_ff;
   logic [15:0]             rsp_value_ff;
   logic                    rsp_enable_ff;
   logic                    rsp_fire_ff;
   logic [15:0]             rsp_now_us_ff;
   logic [31:0]             rsp_taken_ff;

   logic [15:0]             period;
   logic [9:0]              upc;
   logic [NOW_WIDTH-1:0]    now_prod;
   logic [25:0]             us_prod;
   logic [15:0]             diff_us;
   logic [14:0]             quo_lo;
   logic [14:0]             step;
   logic [TARGET_WIDTH:0]   gap;
   logic                    late;
   logic [TARGET_WIDTH-1:0] dist_full;

   logic                    div_start;
   logic [DIV_WIDTH-1:0]    div_dividend;
   logic [REM_WIDTH-1:0]    div_divisor;
   logic                    div_busy;
   logic [DIV_WIDTH-1:0]    div_quo;
   logic [REM_WIDTH-1:0]    div_rem;

   logic                    commit_match;
   logic                    match_done;

   assign period = (counts_per_period == '0) ? 16'd1 : counts_per_period;
   assign upc    = (count_us == '0) ? 10'd1 : count_us;

   assign now_prod = ticks_ff * period;
   assign us_prod  = now_ff[15:0] * upc;
   assign diff_us  = alarm_ff - now_us_ff;

   // a negative or sub-count delta lands one count ahead
   assign quo_lo = div_quo[14:0];
   assign step   = (!diff_us[15] && quo_lo != '0) ? quo_lo : 15'd1;

   assign gap       = {1'b0, target_ff} - {2'b00, now_ff};
   assign late      = gap[TARGET_WIDTH] || (gap == '0);
   assign dist_full = late ? TARGET_WIDTH'(1) : gap[TARGET_WIDTH-1:0];

   assign div_start    = cmd.sched_div || cmd.arm_div;
   assign div_dividend = cmd.arm_div ? ({1'b0, fine_ff} + {1'b0, dist_ff})
                                     : {2'b00, diff_us[14:0]};
   assign div_divisor  = cmd.arm_div ? period : {6'b0, upc};

   cas_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      target_in = target_ff;
      armed_in  = armed_ff;
      irq_in    = irq_ff;
      match_in  = match_ff;
      if (cmd.sched_set) begin
         target_in = {1'b0, now_ff} + TARGET_WIDTH'(step);
         armed_in  = 1'b1;
      end
      if (cmd.commit) begin
         if (arm_ok_ff) begin
            irq_in = 1'b1;
         end
         if (mode_ff == MODE_MATCH) begin
            match_in = match_ff + 32'd1;
            irq_in   = 1'b0;
            armed_in = 1'b0;
         end else if (mode_ff == MODE_INIT) begin
            target_in = '0;
            irq_in    = 1'b0;
            armed_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         armed_ff     <= 1'b0;
         irq_ff       <= 1'b0;
         match_ff     <= '0;
         arm_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff <= target_in;
         armed_ff  <= armed_in;
         irq_ff    <= irq_in;
         match_ff  <= match_in;
         if (cmd.load) begin
            arm_ok_ff <= 1'b0;
         end else if (cmd.arm_eval) begin
            arm_ok_ff <= armed_ff && (dist_full < TARGET_WIDTH'(period));
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (cmd.load) begin
         mode_ff  <= req_tuser;
         ticks_ff <= req_tdata[31:0];
         fine_ff  <= req_tdata[47:32];
         alarm_ff <= req_tdata[63:48];
      end
      if (cmd.mul_now) begin
         now_ff <= now_prod + {32'b0, fine_ff};
      end
      if (cmd.mul_us) begin
         now_us_ff <= us_prod[15:0];
      end
      if (cmd.arm_eval) begin
         dist_ff <= dist_full[15:0];
      end
      if (cmd.commit) begin
         rsp_written_ff <= arm_ok_ff;
         rsp_value_ff   <= arm_ok_ff ? div_rem : 16'd0;
         rsp_enable_ff  <= irq_in;
         rsp_fire_ff    <= mode_ff == MODE_MATCH;
         rsp_now_us_ff  <= now_us_ff;
         rsp_taken_ff   <= match_in;
      end
   end

   assign status.mode     = mode_ff;
   assign status.div_busy = div_busy;
   assign status.arm_ok   = arm_ok_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_taken_ff, rsp_now_us_ff, rsp_fire_ff, rsp_enable_ff,
                        rsp_value_ff, rsp_written_ff};

   assign commit_match = cmd.commit && mode_ff == MODE_MATCH;
   assign match_done   = !armed_ff && !irq_ff && rsp_fire_ff;

   `CAS_ASSERT_IMPLIES(a_written_enables, clock, reset, rsp_valid_ff && rsp_written_ff, rsp_enable_ff)
   `CAS_ASSERT_NEXT(a_match_disarms, clock, reset, commit_match, match_done)
   `CAS_ASSERT_IMPLIES(a_arm_div_armed, clock, reset, cmd.arm_div, arm_ok_ff && armed_ff)

endmodule

// File: sv/cas_ctrl.sv
// ----------------------------------------------------------------------------
// cas_ctrl
// Sequencer for one item: multiply, divide, arm check and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "compare_alarm_scheduler_top_assert.svh"

module cas_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output cas_pkg::cas_cmd_type    cmd,
   input  cas_pkg::cas_status_type status
);
   import cas_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_NOW,
      ST_MUL_US,
      ST_SCHED_DIV,
      ST_SCHED_WAIT,
      ST_SCHED_SET,
      ST_ARM_EVAL,
      ST_ARM_DIV,
      ST_ARM_WAIT,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // leave idle only on an accepted item
            if (req_tvalid && ready_ff) begin
               state_in = ST_MUL_NOW;
            end
         end
         ST_MUL_NOW:   state_in = ST_MUL_US;
         ST_MUL_US: begin
            priority if (status.mode == MODE_SCHEDULE) begin
               state_in = ST_SCHED_DIV;
            end else if (status.mode == MODE_TICK) begin
               state_in = ST_ARM_EVAL;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_SCHED_DIV: state_in = ST_SCHED_WAIT;
         ST_SCHED_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_SCHED_SET;
            end
         end
         ST_SCHED_SET: state_in = ST_ARM_EVAL;
         ST_ARM_EVAL:  state_in = ST_ARM_DIV;
         ST_ARM_DIV: begin
            // nothing to program: skip the modulo
            state_in = status.arm_ok ? ST_ARM_WAIT : ST_COMMIT;
         end
         ST_ARM_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= state_in == ST_IDLE;
      end
   end

   assign req_tready = ready_ff;

   assign cmd.load      = req_tvalid && ready_ff;
   assign cmd.mul_now   = state_ff == ST_MUL_NOW;
   assign cmd.mul_us    = state_ff == ST_MUL_US;
   assign cmd.sched_div = state_ff == ST_SCHED_DIV;
   assign cmd.sched_set = state_ff == ST_SCHED_SET;
   assign cmd.arm_eval  = state_ff == ST_ARM_EVAL;
   assign cmd.arm_div   = (state_ff == ST_ARM_DIV) && status.arm_ok;
   assign cmd.commit    = (state_ff == ST_COMMIT) && !status.out_busy;

   `CAS_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == ST_MUL_NOW)
   `CAS_ASSERT_IMPLIES(a_commit_free, clock, reset, cmd.commit, !status.out_busy)
   `CAS_ASSERT_NEXT(a_div_started, clock, reset, cmd.sched_div || cmd.arm_div, status.div_busy)

endmodule

// File: sv/compare_alarm_scheduler_top.sv
// ----------------------------------------------------------------------------
// compare_alarm_scheduler_top
// One-shot compare alarm scheduler on a periodically reloading counter.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event item: mode in tuser, and the period tick count,
//   counter value and alarm time in tdata. rsp_* returns one result item per
//   event: compare programming, interrupt enable, fire, time in microseconds
//   and the match count. csr_* sets the counts per period and the
//   microseconds per count; write only while the block is idle.
//   Match, read and init go from the multiplies straight to the result;
//   tick adds the arm check and, if a compare is due, a divide; schedule
//   adds a divide before that. All divides run on the shared restoring
//   divider; one item is in work at a time, back in idle before the next.
//   Reset restores the register defaults (500 counts, 2 us per count) and
//   clears the alarm, interrupt enable and match count.
//   The result register holds while rsp_tready is low; the next item is
//   still taken and is worked up to its hand-off, where it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module compare_alarm_scheduler_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [31:0] period_ticks, [47:32] fine_count, [63:48] alarm_time_us
   input  logic [cas_pkg::IN_WIDTH-1:0]   req_tdata,
   // [2:0] mode
   input  logic [cas_pkg::MODE_WIDTH-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] compare_written, [16:1] compare_value, [17] compare_enable,
   // [18] fire, [34:19] now_us, [66:35] alarms_taken, [71:67] zero
   output logic [cas_pkg::OUT_WIDTH-1:0]  rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import cas_pkg::*;

   logic [15:0]    period_ff;
   logic [9:0]     upc_ff;
   logic           csr_write;
   cas_cmd_type    cmd;
   cas_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd500;
         upc_ff    <= 10'd2;
      end else if (csr_write) begin
         if (csr_paddr[2]) begin
            upc_ff <= csr_pwdata[9:0];
         end else begin
            period_ff <= csr_pwdata[15:0];
         end
      end
   end

   assign csr_prdata = csr_paddr[2] ? {22'b0, upc_ff} : {16'b0, period_ff};

   cas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cas_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .counts_per_period (period_ff),
      .count_us          (upc_ff),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tdata         (rsp_tdata)
   );

endmodule

// File: verif/cas_tb_pkg.sv
// ----------------------------------------------------------------------------
// cas_tb_pkg
// Register map of the compare alarm scheduler, shared by the testbench files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cas_tb_pkg;

   // byte addresses on the csr port
   localparam logic [2:0] REG_COUNTS_PER_PERIOD = 3'd0;
   localparam logic [2:0] REG_US_PER_COUNT      = 3'd4;

endpackage

// File: verif/cas_checker.sv
// ----------------------------------------------------------------------------
// cas_checker
// Watches the event, result and csr channels of the compare alarm scheduler,
// predicts one result per accepted event and compares it field by field
// against the results the block hands out, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cas_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // [31:0] period_ticks, [47:32] fine_count, [63:48] alarm_time_us
   input  logic [cas_pkg::IN_WIDTH-1:0]   req_tdata,
   // [2:0] mode
   input  logic [cas_pkg::MODE_WIDTH-1:0] req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] compare_written, [16:1] compare_value, [17] compare_enable,
   // [18] fire, [34:19] now_us, [66:35] alarms_taken, [71:67] zero
   input  logic [cas_pkg::OUT_WIDTH-1:0]  rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending,
   output int                             results_checked,
   output int                             compares_programmed,
   output int                             fires_seen
);

   import cas_pkg::*;
   import cas_tb_pkg::*;

   // packed in the same bit order as rsp_tdata[66:0]
   typedef struct packed {
      logic [31:0] taken;
      logic [15:0] now_us;
      logic        fire;
      logic        enable;
      logic [15:0] value;
      logic        written;
   } alarm_result_t;

   logic [15:0]   cfg_period;
   logic [9:0]    cfg_upc;
   logic [63:0]   alarm_target;
   logic          alarm_armed;
   logic          irq_on;
   logic [31:0]   match_total;
   alarm_result_t expected_q[$];

   function automatic void program_compare(input logic [63:0] now,
                                           input logic [63:0] period,
                                           inout alarm_result_t r);
      logic [63:0] tgt;
      if (!alarm_armed) return;
      tgt = alarm_target;
      // a target already due fires on the next count
      if (tgt <= now) tgt = now + 64'd1;
      // beyond this period: leave it for a later tick
      if (tgt - now >= period) return;
      r.written = 1'b1;
      r.value   = 16'(tgt % period);
      irq_on    = 1'b1;
   endfunction

   function automatic alarm_result_t predict_alarm(input logic [2:0]  mode,
                                                   input logic [31:0] ticks,
                                                   input logic [15:0] fine,
                                                   input logic [15:0] alarm);
      logic [63:0]   period;
      logic [63:0]   upc;
      logic [63:0]   now;
      logic [15:0]   diff;
      int            skew_us;
      int            skew_counts;
      alarm_result_t r;
      period   = (cfg_period == 16'd0) ? 64'd1 : 64'(cfg_period);
      upc      = (cfg_upc == 10'd0) ? 64'd1 : 64'(cfg_upc);
      now      = 64'(ticks) * period + 64'(fine);
      r        = '0;
      r.now_us = 16'(now * upc);
      case (mode)
         MODE_SCHEDULE: begin
            diff         = alarm - r.now_us;
            skew_us      = $signed(diff);
            skew_counts  = skew_us / int'(upc);
            alarm_target = (skew_counts > 0) ? now + 64'(skew_counts) : now + 64'd1;
            alarm_armed  = 1'b1;
            program_compare(now, period, r);
         end
         MODE_TICK: begin
            program_compare(now, period, r);
         end
         MODE_MATCH: begin
            match_total = match_total + 32'd1;
            irq_on      = 1'b0;
            alarm_armed = 1'b0;
            r.fire      = 1'b1;
         end
         MODE_INIT: begin
            alarm_armed  = 1'b0;
            alarm_target = '0;
            irq_on       = 1'b0;
         end
         default: ;  // read now and the unused modes leave the state alone
      endcase
      r.enable = irq_on;
      r.taken  = match_total;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   initial begin
      fail_count          = 0;
      pending             = 0;
      results_checked     = 0;
      compares_programmed = 0;
      fires_seen          = 0;
   end

   always @(posedge clock) begin
      alarm_result_t got;
      alarm_result_t want;
      if (reset) begin
         cfg_period   = 16'd500;
         cfg_upc      = 10'd2;
         alarm_target = '0;
         alarm_armed  = 1'b0;
         irq_on       = 1'b0;
         match_total  = '0;
         expected_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr)
               REG_COUNTS_PER_PERIOD: cfg_period = csr_pwdata[15:0];
               REG_US_PER_COUNT:      cfg_upc    = csr_pwdata[9:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = alarm_result_t'(rsp_tdata[66:0]);
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %0h", $time, got);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("compare_written", 32'(want.written), 32'(got.written));
               check_field("compare_value", 32'(want.value), 32'(got.value));
               check_field("compare_enable", 32'(want.enable), 32'(got.enable));
               check_field("fire", 32'(want.fire), 32'(got.fire));
               check_field("now_us", 32'(want.now_us), 32'(got.now_us));
               check_field("alarms_taken", want.taken, got.taken);
               results_checked++;
               if (want.written) compares_programmed++;
               if (want.fire) fires_seen++;
            end
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(predict_alarm(req_tuser, req_tdata[31:0],
                                               req_tdata[47:32], req_tdata[63:48]));
      end
      pending = expected_q.size();
   end

endmodule

// File: verif/tb_compare_alarm_scheduler_top.sv
// ----------------------------------------------------------------------------
// tb_compare_alarm_scheduler_top
// Drives events and register writes into the compare alarm scheduler: a
// directed run over the corner cases, then random schedule/tick/match
// sequences with noise under several period and rate settings, with random
// gaps on both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_compare_alarm_scheduler_top;

   import cas_pkg::*;
   import cas_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int NUM_PHASES     = 10;
   localparam int PHASE_ITEMS    = 143;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_WIDTH-1:0]   req_tdata = '0;
   logic [MODE_WIDTH-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [OUT_WIDTH-1:0]  rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [2:0]            csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int pending;
   int results_checked;
   int compares_programmed;
   int fires_seen;

   logic        steady = 1'b0;   // no gaps on either side while set
   int          items_sent = 0;
   int          settings_run = 0;
   int          quiet_cycles = 0;
   logic [15:0] cur_period = 16'd500;
   logic [9:0]  cur_upc = 10'd2;
   logic [31:0] cur_ticks = '0;
   logic [15:0] cur_fine = '0;

   always #5 clock = ~clock;

   compare_alarm_scheduler_top uut (.*);

   cas_checker u_checker (.*);

   always @(negedge clock)
      rsp_tready = steady ? 1'b1 : ($urandom_range(99) >= 18);

   // end the run when nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [63:0] period_eff();
      return (cur_period == 16'd0) ? 64'd1 : 64'(cur_period);
   endfunction

   function automatic logic [63:0] upc_eff();
      return (cur_upc == 10'd0) ? 64'd1 : 64'(cur_upc);
   endfunction

   function automatic logic [15:0] now_us_at(input logic [31:0] t, input logic [15:0] f);
      return 16'((64'(t) * period_eff() + 64'(f)) * upc_eff());
   endfunction

   task automatic send_event(input logic [2:0] mode, input logic [31:0] ticks,
                             input logic [15:0] fine, input logic [15:0] alarm);
      while (!steady && $urandom_range(99) < 18) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {alarm, fine, ticks};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
      items_sent++;
   endtask

   task automatic send_now(input logic [2:0] mode);
      send_event(mode, cur_ticks, cur_fine, 16'($urandom));
   endtask

   task automatic schedule_in(input int offset_us);
      send_event(MODE_SCHEDULE, cur_ticks, cur_fine,
                 now_us_at(cur_ticks, cur_fine) + 16'(offset_us));
   endtask

   task automatic advance_time();
      if ($urandom_range(99) < 5)
         cur_ticks = $urandom;
      else
         cur_ticks = cur_ticks + $urandom_range(0, 2);
      cur_fine = 16'($urandom_range(0, int'(period_eff()) - 1));
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic drain();
      while (pending != 0) @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] period, input logic [9:0] upc);
      drain();
      csr_write(REG_COUNTS_PER_PERIOD, {16'd0, period});
      csr_write(REG_US_PER_COUNT, {22'd0, upc});
      cur_period = period;
      cur_upc    = upc;
      settings_run++;
   endtask

   // at times an init, a schedule, a few ticks toward the target, then usually the match
   task automatic alarm_sequence();
      int span;
      int kind;
      int n_ticks;
      if ($urandom_range(99) < 10) send_now(MODE_INIT);
      advance_time();
      span = int'(period_eff() * upc_eff() * 2);
      if (span > 32767) span = 32767;
      kind = $urandom_range(0, 9);
      case (kind)
         0:       schedule_in(0);
         1:       schedule_in(-int'($urandom_range(1, 32768)));
         2:       schedule_in($urandom_range(0, 32767));
         default: schedule_in($urandom_range(1, span));
      endcase
      n_ticks = $urandom_range(0, 4);
      repeat (n_ticks) begin
         if ($urandom_range(1)) cur_ticks = cur_ticks + 1;
         cur_fine = 16'($urandom_range(0, int'(period_eff()) - 1));
         send_now(MODE_TICK);
      end
      if ($urandom_range(99) < 70) send_now(MODE_MATCH);
      if ($urandom_range(99) < 30) send_now(MODE_READ);
   endtask

   task automatic directed_run();
      send_event(MODE_READ, 32'd0, 16'd0, 16'd0);
      send_event(MODE_READ, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      // match with nothing armed still counts and fires
      send_event(MODE_MATCH, 32'd0, 16'd0, 16'd0);
      cur_ticks = 32'd10;
      cur_fine  = 16'd100;
      schedule_in(0);                // already due: armed for the next count
      send_now(MODE_MATCH);
      schedule_in(200);              // lands within this period
      send_now(MODE_TICK);
      cur_ticks = 32'd11;
      send_now(MODE_TICK);           // target now in the past
      send_now(MODE_MATCH);
      schedule_in(30000);            // many periods out: nothing programmed
      send_now(MODE_TICK);
      send_event(MODE_TICK, 32'd41, 16'd0, 16'd0);  // retry reaches it
      send_now(MODE_INIT);
      send_now(MODE_TICK);           // disarmed by init
      schedule_in(-32768);
      schedule_in(-1);
      send_event(MODE_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000);
      send_event(MODE_SCHEDULE, 32'd0, 16'd0, 16'hFFFF);
      send_event(3'd5, $urandom, 16'($urandom), 16'($urandom));
      send_event(3'd6, $urandom, 16'($urandom), 16'($urandom));
      send_event(3'd7, $urandom, 16'($urandom), 16'($urandom));
      send_now(MODE_MATCH);
      send_now(MODE_INIT);
   endtask

   initial begin
      logic [15:0] phase_period[NUM_PHASES];
      logic [9:0]  phase_upc[NUM_PHASES];
      int          target;
      phase_period = '{16'd500, 16'd1, 16'd65535, 16'd0, 16'd7, 16'd1000, 16'd65535,
                       16'd1, 16'($urandom_range(2, 5000)), 16'($urandom_range(2, 65535))};
      phase_upc    = '{10'd2, 10'd1, 10'd1000, 10'd0, 10'd3, 10'd1, 10'd1, 10'd1000,
                       10'($urandom_range(1, 1000)), 10'($urandom_range(1, 1000))};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_run();

      target = items_sent;
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_config(phase_period[p], phase_upc[p]);
         steady = (p == 1);
         target = target + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(99) < 15)
               send_event(3'($urandom), $urandom, 16'($urandom), 16'($urandom));
            else
               alarm_sequence();
         end
      end
      steady = 1'b0;

      drain();
      repeat (60) @(posedge clock);
      $display("Sent %0d events over %0d register settings; %0d results checked,",
               items_sent, settings_run, results_checked);
      $display("%0d with a compare programmed and %0d with an alarm fired.",
               compares_programmed, fires_seen);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
